### rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, codes and arithmetic helpers for the sub-pixel plot LED
// matrix frame buffer.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Command codes carried by a request.
  localparam logic [1:0] CMD_PLOT  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG   = 1'd1;

  // Wiring orientation codes (connection angle and strip direction).
  localparam logic [2:0] ORI_IDENT         = 3'd0;
  localparam logic [2:0] ORI_SWAP          = 3'd1;
  localparam logic [2:0] ORI_FLIP_Y        = 3'd2;
  localparam logic [2:0] ORI_SWAP_FLIP_Y   = 3'd3;
  localparam logic [2:0] ORI_FLIP_XY       = 3'd4;
  localparam logic [2:0] ORI_SWAP_FLIP_XY  = 3'd5;
  localparam logic [2:0] ORI_FLIP_X        = 3'd6;
  localparam logic [2:0] ORI_SWAP_FLIP_X   = 3'd7;

  // Width of a matrix coordinate and of the strip index arithmetic.
  localparam int COORD_W = 7;
  localparam int IDX_W   = 13;

  // Configuration passed to the coordinate mapper.
  typedef struct packed {
    logic [2:0] orient;
    logic       progressive;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WGT,
    ST_NB_RD,
    ST_NB_WR,
    ST_EXW,
    ST_RDX,
    ST_RDD
  } state_t;

  // Intensity of an 8-bit fraction: (f * 255) >> 8.
  function automatic logic [7:0] frac_level(input logic [7:0] f);
    logic [15:0] p;
    p = {f, 8'h00} - {8'h00, f};
    return p[15:8];
  endfunction

  // Wu weight of an intensity pair: (a*b + a + b) >> 8.
  function automatic logic [7:0] corner_weight(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = 17'(a) * 17'(b) + 17'(a) + 17'(b);
    return s[15:8];
  endfunction

  // Saturating 8-bit add.
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

### rtl/wsp_map.sv
// ----------------------------------------------------------------------------
// wsp_map
// Maps an on-matrix pixel coordinate to its position along the LED strip,
// following the wiring orientation and the serpentine or progressive rows.
// ----------------------------------------------------------------------------
module wsp_map import wsp_pkg::*; #(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16,
  parameter int AW            = 8
) (
  input  cfg_t                cfg,
  input  logic [COORD_W-2:0]  x,
  input  logic [COORD_W-2:0]  y,
  output logic [AW-1:0]       index
);

  localparam logic [COORD_W-1:0] WL = COORD_W'(MATRIX_WIDTH);
  localparam logic [COORD_W-1:0] HL = COORD_W'(MATRIX_HEIGHT);
  localparam logic [COORD_W-1:0] WM1 = COORD_W'(MATRIX_WIDTH - 1);
  localparam logic [COORD_W-1:0] HM1 = COORD_W'(MATRIX_HEIGHT - 1);

  logic [COORD_W-1:0] xe, ye, tx, ty, len;
  logic [IDX_W-1:0]   row_base, idx_full;

  // Pick the mapped column, row and row length for the orientation.
  always_comb begin
    xe = {1'b0, x};
    ye = {1'b0, y};
    case (cfg.orient)
      ORI_IDENT: begin
        tx = xe; ty = ye; len = WL;
      end
      ORI_SWAP: begin
        tx = ye; ty = xe; len = HL;
      end
      ORI_FLIP_Y: begin
        tx = xe; ty = HM1 - ye; len = WL;
      end
      ORI_SWAP_FLIP_Y: begin
        tx = HM1 - ye; ty = xe; len = HL;
      end
      ORI_FLIP_XY: begin
        tx = WM1 - xe; ty = HM1 - ye; len = WL;
      end
      ORI_SWAP_FLIP_XY: begin
        tx = HM1 - ye; ty = WM1 - xe; len = HL;
      end
      ORI_FLIP_X: begin
        tx = WM1 - xe; ty = ye; len = WL;
      end
      ORI_SWAP_FLIP_X: begin
        tx = ye; ty = WM1 - xe; len = HL;
      end
      default: begin
        tx = xe; ty = ye; len = WL;
      end
    endcase
  end

  // Odd rows run backwards unless the rows are progressive.
  always_comb begin
    row_base = IDX_W'(ty) * IDX_W'(len);
    if (ty[0] && !cfg.progressive) begin
      idx_full = row_base + IDX_W'(len) - IDX_W'(1) - IDX_W'(tx);
    end else begin
      idx_full = row_base + IDX_W'(tx);
    end
  end

  assign index = idx_full[AW-1:0];

endmodule

### rtl/wsp_fbuf.sv
// ----------------------------------------------------------------------------
// wsp_fbuf
// Frame buffer storage: one write port and one read port with registered
// read data, one pixel of 24 bits per entry.
// ----------------------------------------------------------------------------
module wsp_fbuf import wsp_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem_r [DEPTH];
  logic [23:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wu_subpixel_plot_led_matrix_top.sv
// ----------------------------------------------------------------------------
// wu_subpixel_plot_led_matrix_top
// RGB frame buffer for an LED matrix with anti-aliased sub-pixel plotting,
// exact pixel writes and reads by strip position.
// ----------------------------------------------------------------------------
// A plot visits the four neighbors in turn; each on-matrix neighbor is a read
// and a write of the buffer, each other one is skipped. A new request is taken
// only in idle, once the last one is through. A read result is registered in
// the buffer's read port and then in the result register.
// Reset: a clearing pass over all MATRIX_WIDTH*MATRIX_HEIGHT entries zeroes the
// buffer; in_stall stays high until it ends.
module wu_subpixel_plot_led_matrix_top import wsp_pkg::*; #(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [11:0]          in_x_pos,
  input  logic [11:0]          in_y_pos,
  input  logic [8:0]           in_pixel_index,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_read_red,
  output logic [7:0]           out_read_green,
  output logic [7:0]           out_read_blue,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [2:0]           cfg_data
);

  localparam int PIX = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
  localparam logic [AW-1:0]      LAST_ADDR = AW'(PIX - 1);
  localparam logic [IDX_W-1:0]   PIX_L     = IDX_W'(PIX);
  localparam logic [COORD_W-1:0] WL        = COORD_W'(MATRIX_WIDTH);
  localparam logic [COORD_W-1:0] HL        = COORD_W'(MATRIX_HEIGHT);

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  cmd_r;
  logic [11:0] xpos_r, ypos_r;
  logic [8:0]  idx_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic [7:0]  wgt_r [4];
  logic [7:0]  sc_red_r, sc_green_r, sc_blue_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rd_red_r, rd_green_r, rd_blue_r;
  logic        load_out;
  logic        out_zero_r;
  cfg_t        cfg_r;

  logic        take;
  logic        load_wgt, load_scale;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic        on_matrix;
  logic [AW-1:0] map_idx;
  logic [IDX_W-1:0] idx_ext;
  logic        idx_ok;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata, mem_rdata;

  logic [7:0]  xx, yy, ix, iy;
  logic [15:0] prod_r, prod_g, prod_b;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIENT: cfg_r.orient <= cfg_data;
        CFG_PROG:   cfg_r.progressive <= cfg_data[0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  // Current pixel: the neighbor selected by k for a plot, else the
  // integer coordinate itself.
  assign cur_x = COORD_W'(xpos_r[11:8]) + COORD_W'(k_r[0]);
  assign cur_y = COORD_W'(ypos_r[11:8]) + COORD_W'(k_r[1]);
  assign on_matrix = (cur_x < WL) && (cur_y < HL);

  wsp_map #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT),
    .AW            (AW)
  ) u_map (
    .cfg   (cfg_r),
    .x     (cur_x[COORD_W-2:0]),
    .y     (cur_y[COORD_W-2:0]),
    .index (map_idx)
  );

  // Strip index check for reads.
  assign idx_ext = IDX_W'(idx_r);
  assign idx_ok  = idx_ext < PIX_L;

  // Sequencer: next state, memory port control and load enables.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    k_nxt       = k_r;
    take        = 1'b0;
    load_wgt    = 1'b0;
    load_scale  = 1'b0;
    load_out    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = map_idx;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = map_idx;
    in_stall    = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        k_nxt    = 2'd0;
        if (in_valid) begin
          take = 1'b1;
          case (in_cmd)
            CMD_PLOT:  state_nxt = ST_WGT;
            CMD_WRITE: state_nxt = ST_EXW;
            CMD_READ:  state_nxt = ST_RDX;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WGT: begin
        load_wgt  = 1'b1;
        state_nxt = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (on_matrix) begin
          mem_re     = 1'b1;
          load_scale = 1'b1;
          state_nxt  = ST_NB_WR;
        end else begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NB_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {sat_add(mem_rdata[23:16], sc_red_r),
                     sat_add(mem_rdata[15:8], sc_green_r),
                     sat_add(mem_rdata[7:0], sc_blue_r)};
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? ST_IDLE : ST_NB_RD;
      end
      ST_EXW: begin
        mem_we    = on_matrix;
        mem_wdata = {red_r, green_r, blue_r};
        state_nxt = ST_IDLE;
      end
      ST_RDX: begin
        mem_re    = idx_ok;
        mem_raddr = idx_ext[AW-1:0];
        state_nxt = ST_RDD;
      end
      ST_RDD: begin
        // Wait here while an earlier result is still held.
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      k_r       <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      k_r       <= k_nxt;
    end
  end

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r   <= in_cmd;
      xpos_r  <= in_x_pos;
      ypos_r  <= in_y_pos;
      idx_r   <= in_pixel_index;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
  end

  // Wu weights of the four neighbors from the coordinate fractions.
  always_comb begin
    xx = frac_level(xpos_r[7:0]);
    yy = frac_level(ypos_r[7:0]);
    ix = 8'hFF - xx;
    iy = 8'hFF - yy;
  end

  always_ff @(posedge clk) begin
    if (load_wgt && cmd_r == CMD_PLOT) begin
      wgt_r[0] <= corner_weight(ix, iy);
      wgt_r[1] <= corner_weight(xx, iy);
      wgt_r[2] <= corner_weight(ix, yy);
      wgt_r[3] <= corner_weight(xx, yy);
    end
  end

  // Colour scaled by the current neighbor's weight, ready for the write.
  always_comb begin
    prod_r = 16'(red_r) * 16'(wgt_r[k_r]);
    prod_g = 16'(green_r) * 16'(wgt_r[k_r]);
    prod_b = 16'(blue_r) * 16'(wgt_r[k_r]);
  end

  always_ff @(posedge clk) begin
    if (load_scale) begin
      sc_red_r   <= prod_r[15:8];
      sc_green_r <= prod_g[15:8];
      sc_blue_r  <= prod_b[15:8];
    end
  end

  wsp_fbuf #(
    .DEPTH (PIX),
    .AW    (AW)
  ) u_fbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Remember whether the pending read was out of range.
  always_ff @(posedge clk) begin
    if (state_r == ST_RDX) begin
      out_zero_r <= !idx_ok;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rd_red_r   <= out_zero_r ? 8'h00 : mem_rdata[23:16];
      rd_green_r <= out_zero_r ? 8'h00 : mem_rdata[15:8];
      rd_blue_r  <= out_zero_r ? 8'h00 : mem_rdata[7:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_red   = rd_red_r;
  assign out_read_green = rd_green_r;
  assign out_read_blue  = rd_blue_r;

endmodule
